### rtl/pacs_pkg.sv
// Shared types, token constants and defaults for the PDF active-content screen.
package pacs_pkg;

  localparam int MAX_DEPTH_DEF  = 255;
  localparam int COUNT_BITS_DEF = 32;
  localparam int OUT_COUNT_BITS = 32;
  localparam int HIST_BYTES     = 12;

  localparam int TOK_JS_LEN     = 11;
  localparam int TOK_LAUNCH_LEN = 7;
  localparam int TOK_EMBED_LEN  = 13;

  localparam logic [TOK_JS_LEN-1:0][7:0]     TOK_JS     = "/JavaScript";
  localparam logic [TOK_LAUNCH_LEN-1:0][7:0] TOK_LAUNCH = "/Launch";
  localparam logic [TOK_EMBED_LEN-1:0][7:0]  TOK_EMBED  = "/EmbeddedFile";

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_PRINT  = 8'h20;

  localparam int HIT_JS     = 0;
  localparam int HIT_LAUNCH = 1;
  localparam int HIT_EMBED  = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic                      blocked;
    logic [2:0]                token_hits;
    logic [OUT_COUNT_BITS-1:0] text_count;
  } out_word_t;

  typedef struct packed {
    logic fire;
    logic last;
  } step_t;

endpackage

### rtl/pacs_window.sv
// Byte history shift line and forbidden-token matcher with sticky hit mask.
module pacs_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pacs_pkg::step_t    step_i,
  input  logic [7:0]         data_byte_i,
  output logic [2:0]         hits_next_o
);
  import pacs_pkg::*;

  logic [HIST_BYTES-1:0][7:0] hist_q;
  logic [HIST_BYTES:0][7:0]   win;
  logic [2:0]                 hit_mask_q;
  logic [2:0]                 match;

  assign win = {hist_q, data_byte_i};

  always_comb begin
    match = 3'b000;
    match[HIT_JS]     = (win[TOK_JS_LEN-1:0] == TOK_JS);
    match[HIT_LAUNCH] = (win[TOK_LAUNCH_LEN-1:0] == TOK_LAUNCH);
    match[HIT_EMBED]  = (win[TOK_EMBED_LEN-1:0] == TOK_EMBED);
  end

  assign hits_next_o = hit_mask_q | match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      hit_mask_q <= 3'b000;
    end else if (step_i.fire) begin
      if (step_i.last) begin
        hist_q     <= '0;
        hit_mask_q <= 3'b000;
      end else begin
        hist_q     <= win[HIST_BYTES-1:0];
        hit_mask_q <= hits_next_o;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && step_i.last |=> (hit_mask_q == 3'b000) && (hist_q == '0))
    else $error("window state not cleared after last word");

endmodule

### rtl/pacs_counter.sv
// Literal-string depth, escape and saturating text byte counter.
module pacs_counter #(
  parameter int MAX_DEPTH  = pacs_pkg::MAX_DEPTH_DEF,
  parameter int COUNT_BITS = pacs_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pacs_pkg::step_t       step_i,
  input  logic [7:0]            data_byte_i,
  output logic [COUNT_BITS-1:0] tally_next_o
);
  import pacs_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [DW-1:0]         depth_q, depth_d;
  logic                  esc_q, esc_d;
  logic [COUNT_BITS-1:0] tally_q, tally_d;
  logic                  count;

  always_comb begin
    count   = 1'b0;
    depth_d = depth_q;
    esc_d   = esc_q;
    if (depth_q == '0) begin
      if (data_byte_i == CH_LPAREN) depth_d = DW'(1);
    end else if (esc_q) begin
      esc_d = 1'b0;
      count = 1'b1;
    end else if (data_byte_i == CH_BSLASH) begin
      esc_d = 1'b1;
    end else if (data_byte_i == CH_LPAREN) begin
      if (depth_q < DW'(MAX_DEPTH)) depth_d = depth_q + DW'(1);
    end else if (data_byte_i == CH_RPAREN) begin
      depth_d = depth_q - DW'(1);
    end else if (data_byte_i >= CH_PRINT) begin
      count = 1'b1;
    end
    tally_d = (count && !(&tally_q)) ? tally_q + COUNT_BITS'(1) : tally_q;
  end

  assign tally_next_o = tally_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      esc_q   <= 1'b0;
      tally_q <= '0;
    end else if (step_i.fire) begin
      if (step_i.last) begin
        depth_q <= '0;
        esc_q   <= 1'b0;
        tally_q <= '0;
      end else begin
        depth_q <= depth_d;
        esc_q   <= esc_d;
        tally_q <= tally_d;
      end
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_DEPTH))
    else $error("nesting depth above limit");

  a_escape_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> depth_q != '0)
    else $error("escape pending outside a string");

endmodule

### rtl/pdf_active_content_screen_top.sv
// Top level of the PDF active-content screen: input register, step logic, result register.
//
//   channel | port group                       | carries
//   --------+----------------------------------+-----------------------------------
//   in      | in_valid_i in_ready_o in_word_i  | one file byte and last-byte flag
//   out     | out_valid_o out_ready_i out_word_o | verdict, token hits, text count
//
// One word enters per cycle while no held result stalls a last word; the result is registered when its last word steps.
// The step logic from input register to state and result register is combinational.
// Reset clears the history, hit mask, depth, escape and count, and both valid flags.
// A held result stalls only a further last word; other words keep flowing.
module pdf_active_content_screen_top #(
  parameter int MAX_DEPTH  = pacs_pkg::MAX_DEPTH_DEF,
  parameter int COUNT_BITS = pacs_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pacs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pacs_pkg::out_word_t out_word_o
);
  import pacs_pkg::*;

  logic                      in_valid_q;
  in_word_t                  in_q;
  logic                      out_valid_q;
  out_word_t                 out_q;
  step_t                     step;
  logic [2:0]                hits_next;
  logic [COUNT_BITS-1:0]     tally_next;
  logic [OUT_COUNT_BITS-1:0] tally_out;
  logic                      blocked;

  assign step.fire = in_valid_q && (!in_q.last_byte || !out_valid_q || out_ready_i);
  assign step.last = in_q.last_byte;
  assign in_ready_o = !in_valid_q || step.fire;

  pacs_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_q.data_byte),
    .hits_next_o (hits_next)
  );

  pacs_counter #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_q.data_byte),
    .tally_next_o (tally_next)
  );

  if (COUNT_BITS > OUT_COUNT_BITS) begin : g_sat
    assign tally_out = (|tally_next[COUNT_BITS-1:OUT_COUNT_BITS]) ? '1 :
                       tally_next[OUT_COUNT_BITS-1:0];
  end else begin : g_ext
    assign tally_out = OUT_COUNT_BITS'(tally_next);
  end

  assign blocked = |hits_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (step.fire && step.last) || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.fire && step.last) begin
      out_q.blocked    <= blocked;
      out_q.token_hits <= hits_next;
      out_q.text_count <= blocked ? '0 : tally_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step.fire && step.last && out_valid_q && !out_ready_i))
    else $error("held result overwritten");

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.fire && step.last |=> out_valid_q)
    else $error("last word gave no result");

  a_blocked_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.blocked |-> out_q.text_count == '0)
    else $error("blocked result with nonzero count");

  a_blocked_has_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.blocked == (out_q.token_hits != 3'b000))
    else $error("verdict disagrees with token hits");

endmodule
